FILE: design/ilp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilp_pkg;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_UZERO  = 3'd1,
		PH_UBODY  = 3'd2,
		PH_SMINUS = 3'd3,
		PH_SBODY  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_BIN = 2'd1,
		RX_OCT = 2'd2,
		RX_HEX = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ILLEGAL  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_LC_O  = 8'h6f;
	localparam logic [7:0] CH_UC_O  = 8'h4f;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;

	localparam logic [4:0] DIGIT_NONE = 5'd16;
	localparam logic [2:0] LEAD_NONE  = 3'd7;
	localparam logic [6:0] SIG_MAX    = 7'd127;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} lit_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [1:0]  radix_kind;
	} res_item_t;

	typedef struct packed {
		phase_t     phase;
		radix_t     radix;
		logic [6:0] sig_digits;
		logic [2:0] lead_digit;
		logic       err_illegal;
		logic       err_ovf;
		logic       err_invalid;
		logic       err_empty;
		logic       negate;
		logic       lit_signed;
	} ilp_state_t;

	localparam ilp_state_t STATE_RESET = '{
		phase:       PH_START,
		radix:       RX_DEC,
		sig_digits:  7'd0,
		lead_digit:  3'd0,
		err_illegal: 1'b0,
		err_ovf:     1'b0,
		err_invalid: 1'b0,
		err_empty:   1'b0,
		negate:      1'b0,
		lit_signed:  1'b0
	};

	// digit value in the given radix, DIGIT_NONE if not a digit of it
	function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_t rx);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = 5'(c - CH_ZERO);
		end else if (c inside {[CH_LC_A:CH_LC_F]}) begin
			d = 5'(c - CH_LC_A) + 5'd10;
		end else if (c inside {[CH_UC_A:CH_UC_F]}) begin
			d = 5'(c - CH_UC_A) + 5'd10;
		end
		case (rx)
			RX_DEC: if (d > 5'd9) d = DIGIT_NONE;
			RX_BIN: if (d > 5'd1) d = DIGIT_NONE;
			RX_OCT: if (d > 5'd7) d = DIGIT_NONE;
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] bit_len4(input logic [3:0] v);
		logic [2:0] n;
		if (v[3]) n = 3'd4;
		else if (v[2]) n = 3'd3;
		else if (v[1]) n = 3'd2;
		else if (v[0]) n = 3'd1;
		else n = 3'd0;
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: design/ilp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ilp_step import ilp_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  wire ilp_state_t              state,
	input  wire logic [VALUE_BITS-1:0]   acc,
	input  wire lit_item_t               item,
	input  wire logic                    signed_mode,
	output ilp_state_t                   nxt_state,
	output logic [VALUE_BITS-1:0]        nxt_acc,
	output res_item_t                    result
);

	localparam int WW       = VALUE_BITS + 4;
	localparam int OCT_MAXD = (VALUE_BITS + 2) / 3;
	localparam int HEX_MAXD = (VALUE_BITS + 3) / 4;
	localparam int OCT_LB   = VALUE_BITS - 3 * (OCT_MAXD - 1);
	localparam int HEX_LB   = VALUE_BITS - 4 * (HEX_MAXD - 1);
	localparam logic [6:0] BIN_MAXD_C = 7'(VALUE_BITS);
	localparam logic [6:0] OCT_MAXD_C = 7'(OCT_MAXD);
	localparam logic [6:0] HEX_MAXD_C = 7'(HEX_MAXD);
	localparam logic [2:0] OCT_LB_C   = 3'(OCT_LB);
	localparam logic [2:0] HEX_LB_C   = 3'(HEX_LB);
	localparam logic [WW-1:0] MAX_UNS = WW'({VALUE_BITS{1'b1}});
	localparam logic [WW-1:0] MAX_SGN = WW'({1'b0, {(VALUE_BITS-1){1'b1}}});

	ilp_state_t          ns;
	logic [VALUE_BITS-1:0] na;
	logic                do_body;
	logic [4:0]          d;
	logic [WW-1:0]       wide;
	logic [WW-1:0]       dec_max;
	status_t             st;
	logic                last;
	logic [7:0]          c;

	assign last = item.last_char;
	assign c    = item.char_code;

	always_comb begin
		ns      = state;
		na      = acc;
		do_body = 1'b0;
		if (c == CH_NUL) ns.err_invalid = 1'b1;

		case (state.phase)
			PH_START, PH_SMINUS: begin
				if (state.phase == PH_START) ns.lit_signed = signed_mode;
				if (state.phase == PH_START && !signed_mode) begin
					if (!last && c == CH_ZERO) begin
						ns.phase = PH_UZERO;
					end else begin
						ns.phase = PH_UBODY;
						do_body  = 1'b1;
					end
				end else if (c == CH_MINUS && !last) begin
					ns.negate = ~state.negate;
					ns.phase  = PH_SMINUS;
				end else begin
					ns.phase = PH_SBODY;
					do_body  = 1'b1;
				end
			end
			PH_UZERO: begin
				ns.phase = PH_UBODY;
				if (c == CH_LC_B || c == CH_UC_B) ns.radix = RX_BIN;
				else if (c == CH_LC_O || c == CH_UC_O) ns.radix = RX_OCT;
				else if (c == CH_LC_X || c == CH_UC_X) ns.radix = RX_HEX;
				if (ns.radix != RX_DEC) begin
					if (last) ns.err_empty = 1'b1;
				end else begin
					do_body = 1'b1;
				end
			end
			default: do_body = 1'b1;
		endcase

		// leading zeros are skipped, but never the last character
		if (state.sig_digits == 7'd0 && c == CH_ZERO && !last) do_body = 1'b0;

		d       = digit_of(c, ns.radix);
		wide    = (WW'(acc) << 3) + (WW'(acc) << 1) + WW'(d);
		dec_max = ns.lit_signed ? MAX_SGN : MAX_UNS;

		if (do_body) begin
			if (state.sig_digits == 7'd0) begin
				ns.lead_digit = (d == DIGIT_NONE) ? LEAD_NONE : bit_len4(d[3:0]);
			end
			if (state.sig_digits != SIG_MAX) ns.sig_digits = state.sig_digits + 7'd1;
			if (d == DIGIT_NONE) begin
				ns.err_illegal = 1'b1;
			end else begin
				case (ns.radix)
					RX_DEC: begin
						if (!state.err_ovf) begin
							if (wide > dec_max) ns.err_ovf = 1'b1;
							else na = wide[VALUE_BITS-1:0];
						end
					end
					RX_BIN: na = {acc[VALUE_BITS-2:0], d[0]};
					RX_OCT: na = {acc[VALUE_BITS-4:0], d[2:0]};
					default: na = {acc[VALUE_BITS-5:0], d[3:0]};
				endcase
			end
		end

		// final status, binary/octal/hex put overflow ahead of illegal
		if (ns.err_invalid || ns.err_empty) begin
			st = ST_INVALID;
		end else begin
			case (ns.radix)
				RX_DEC: begin
					if (ns.err_illegal) st = ST_ILLEGAL;
					else if (ns.err_ovf) st = ST_OVERFLOW;
					else st = ST_OK;
				end
				RX_BIN: begin
					if (ns.sig_digits > BIN_MAXD_C) st = ST_OVERFLOW;
					else if (ns.err_illegal) st = ST_ILLEGAL;
					else st = ST_OK;
				end
				RX_OCT: begin
					if (ns.sig_digits > OCT_MAXD_C) st = ST_OVERFLOW;
					else if (ns.sig_digits == OCT_MAXD_C && OCT_LB_C < 3'd3
						&& ns.lead_digit > OCT_LB_C) st = ST_OVERFLOW;
					else if (ns.err_illegal) st = ST_ILLEGAL;
					else st = ST_OK;
				end
				default: begin
					if (ns.sig_digits > HEX_MAXD_C) st = ST_OVERFLOW;
					else if (ns.sig_digits == HEX_MAXD_C && HEX_LB_C < 3'd4
						&& ns.lead_digit > HEX_LB_C) st = ST_OVERFLOW;
					else if (ns.err_illegal) st = ST_ILLEGAL;
					else st = ST_OK;
				end
			endcase
		end

		result.status     = st;
		result.radix_kind = ns.radix;
		if (st != ST_OK) result.value = 64'd0;
		else if (ns.negate) result.value = 64'd0 - 64'(na);
		else result.value = 64'(na);

		if (last) begin
			nxt_state = STATE_RESET;
			nxt_acc   = '0;
		end else begin
			nxt_state = ns;
			nxt_acc   = na;
		end
	end

endmodule

`default_nettype wire

FILE: design/integer_literal_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// lit       in         lit_valid / lit_stall  lit_item (char_code, last_char)
// res       out        res_valid / res_stall  res_item (value, status, radix_kind)
// cfg       in         cfg_valid / cfg_ready  cfg_data (signed_mode)
//
// one character per cycle unless lit is stalled; an item sits in the input register,
// the step logic then updates the literal state and, on the last character,
// loads the result register.
// reset clears the literal state, signed_mode and both valid flags.
// a stalled result holds the result register; only an item carrying the
// last character then waits in the input register and stalls lit.

module integer_literal_parser import ilp_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      lit_valid,
	output logic           lit_stall,
	input  wire lit_item_t lit_item,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_item,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_data
);

	lit_item_t             lit_s1;
	logic                  lit_valid_s1;
	ilp_state_t            state_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  signed_mode_q;
	logic                  res_valid_q;
	res_item_t             res_item_q;

	ilp_state_t            nxt_state;
	logic [VALUE_BITS-1:0] nxt_acc;
	res_item_t             result;
	logic                  advance;
	logic                  lit_take;

	ilp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.state       (state_q),
		.acc         (acc_q),
		.item        (lit_s1),
		.signed_mode (signed_mode_q),
		.nxt_state   (nxt_state),
		.nxt_acc     (nxt_acc),
		.result      (result)
	);

	assign advance   = lit_valid_s1 && (!lit_s1.last_char || !res_valid_q || !res_stall);
	assign lit_stall = lit_valid_s1 && !advance;
	assign lit_take  = lit_valid && !lit_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_valid_s1  <= 1'b0;
			state_q       <= STATE_RESET;
			acc_q         <= '0;
			signed_mode_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) signed_mode_q <= cfg_data;
			if (lit_take) lit_valid_s1 <= 1'b1;
			else if (advance) lit_valid_s1 <= 1'b0;
			if (advance) begin
				state_q <= nxt_state;
				acc_q   <= nxt_acc;
			end
			if (advance && lit_s1.last_char) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lit_take) lit_s1 <= lit_item;
		if (advance && lit_s1.last_char) res_item_q <= result;
	end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ilp_pkg::*;

	localparam int VALUE_BITS = 64;

	class literal_book;
		bit          signed_mode;
		phase_t      ph;
		radix_t      rx;
		logic [63:0] acc;
		int unsigned sig;
		int unsigned lead;
		bit          bad_char;
		bit          too_big;
		bit          nul_seen;
		bit          bare_prefix;
		bit          neg;
		bit          lit_signed;
		res_item_t   parsed[$];
		int unsigned errors;

		function new();
			signed_mode = 1'b0;
			errors = 0;
			clear();
		endfunction

		function void clear();
			ph = PH_START;
			rx = RX_DEC;
			acc = '0;
			sig = 0;
			lead = 0;
			bad_char = 1'b0;
			too_big = 1'b0;
			nul_seen = 1'b0;
			bare_prefix = 1'b0;
			neg = 1'b0;
			lit_signed = 1'b0;
		endfunction

		function int unsigned outstanding();
			return parsed.size();
		endfunction

		function int unsigned digit_bits();
			if (rx == RX_BIN) return 1;
			if (rx == RX_OCT) return 3;
			return 4;
		endfunction

		function void take_digit(logic [7:0] c, bit last);
			int unsigned d;
			int unsigned base;
			int unsigned v;
			logic [63:0] limit;
			if (sig == 0 && c == CH_ZERO && !last) return;
			d = 16;
			if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
			else if (c >= CH_LC_A && c <= CH_LC_F) d = c - CH_LC_A + 10;
			else if (c >= CH_UC_A && c <= CH_UC_F) d = c - CH_UC_A + 10;
			case (rx)
				RX_DEC: base = 10;
				RX_BIN: base = 2;
				RX_OCT: base = 8;
				default: base = 16;
			endcase
			if (d >= base) d = 16;
			if (sig == 0) begin
				if (d > 15) begin
					lead = LEAD_NONE;
				end else begin
					lead = 0;
					v = d;
					while (v != 0) begin
						lead++;
						v = v >> 1;
					end
				end
			end
			if (sig < SIG_MAX) sig++;
			if (d > 15) begin
				bad_char = 1'b1;
				return;
			end
			if (rx == RX_DEC) begin
				limit = lit_signed ? ({64{1'b1}} >> (65 - VALUE_BITS))
					: ({64{1'b1}} >> (64 - VALUE_BITS));
				if (too_big) return;
				if (acc > (limit - 64'(d)) / 64'd10) too_big = 1'b1;
				else acc = acc * 64'd10 + 64'(d);
			end else begin
				acc = (acc << digit_bits()) | 64'(d);
			end
		endfunction

		function status_t literal_status();
			int unsigned rb;
			int unsigned maxd;
			int unsigned lb;
			if (nul_seen || bare_prefix) return ST_INVALID;
			if (rx == RX_DEC) begin
				if (bad_char) return ST_ILLEGAL;
				if (too_big) return ST_OVERFLOW;
				return ST_OK;
			end
			rb = digit_bits();
			maxd = (VALUE_BITS + rb - 1) / rb;
			lb = VALUE_BITS - rb * (maxd - 1);
			if (sig > maxd) return ST_OVERFLOW;
			if (sig == maxd && lb < rb && lead > lb) return ST_OVERFLOW;
			if (bad_char) return ST_ILLEGAL;
			return ST_OK;
		endfunction

		function void minus_or_body(logic [7:0] c, bit last);
			if (c == CH_MINUS && !last) begin
				neg = ~neg;
			end else begin
				ph = PH_SBODY;
				take_digit(c, last);
			end
		endfunction

		function void note_char(logic [7:0] c, bit last);
			res_item_t r;
			status_t   st;
			if (c == CH_NUL) nul_seen = 1'b1;
			case (ph)
				PH_START: begin
					lit_signed = signed_mode;
					if (lit_signed) begin
						ph = PH_SMINUS;
						minus_or_body(c, last);
					end else if (!last && c == CH_ZERO) begin
						ph = PH_UZERO;
					end else begin
						ph = PH_UBODY;
						take_digit(c, last);
					end
				end
				PH_UZERO: begin
					ph = PH_UBODY;
					if (c == CH_LC_B || c == CH_UC_B) rx = RX_BIN;
					else if (c == CH_LC_O || c == CH_UC_O) rx = RX_OCT;
					else if (c == CH_LC_X || c == CH_UC_X) rx = RX_HEX;
					if (rx != RX_DEC) begin
						if (last) bare_prefix = 1'b1;
					end else begin
						take_digit(c, last);
					end
				end
				PH_SMINUS: minus_or_body(c, last);
				default: take_digit(c, last);
			endcase
			if (!last) return;
			st = literal_status();
			r.status = st;
			r.radix_kind = rx;
			if (st != ST_OK) r.value = '0;
			else r.value = neg ? 64'd0 - acc : acc;
			parsed.push_back(r);
			clear();
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
			errors++;
		endtask

		task check_result(res_item_t got);
			res_item_t want;
			if (parsed.size() == 0) begin
				report_mismatch("unexpected item", got.value, '0);
				return;
			end
			want = parsed.pop_front();
			if (got.value !== want.value)
				report_mismatch("value", got.value, want.value);
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.radix_kind !== want.radix_kind)
				report_mismatch("radix_kind", 64'(got.radix_kind), 64'(want.radix_kind));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      lit_valid = 1'b0;
	logic      lit_stall;
	lit_item_t lit_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	literal_book book = new();
	logic [7:0]  lit_text[$];
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          cur_mode = 1'b0;
	int unsigned stall_run = 0;
	int unsigned stall_kind = 0;

	integer_literal_parser #(.VALUE_BITS(VALUE_BITS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.lit_valid (lit_valid),
		.lit_stall (lit_stall),
		.lit_item  (lit_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stall pattern: free runs, coin flips and long stalls
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_kind = $urandom_range(0, 3);
			stall_run = $urandom_range(1, 40);
		end
		stall_run--;
		case (stall_kind)
			0, 1: res_stall <= 1'b0;
			2: res_stall <= 1'($urandom_range(0, 1));
			default: res_stall <= (stall_run % 16) < 9;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) book.check_result(res_item);
	end

	task automatic send_char(logic [7:0] c, logic last);
		int unsigned gap;
		@(negedge clk);
		lit_valid <= 1'b1;
		lit_item <= '{char_code: c, last_char: last};
		do @(posedge clk); while (lit_stall);
		book.note_char(c, last);
		items_sent++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 5);
				burst_left = $urandom_range(1, 16);
				@(negedge clk);
				lit_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_literal();
		for (int i = 0; i < lit_text.size(); i++)
			send_char(lit_text[i], i == lit_text.size() - 1);
	endtask

	task automatic send_text(string s);
		lit_text.delete();
		for (int i = 0; i < s.len(); i++) lit_text.push_back(s[i]);
		send_literal();
	endtask

	// sender holds off until every result is back and the pipeline is empty
	task automatic go_idle();
		@(negedge clk);
		lit_valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(bit m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		book.signed_mode = m;
		cur_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char(int unsigned v);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
	endfunction

	task automatic make_literal(bit sgn);
		int unsigned pick;
		int unsigned n;
		int unsigned base;
		int unsigned maxd;
		int unsigned spot;
		logic [63:0] top;
		logic [63:0] num;
		logic [7:0]  pfx;
		string       s;
		lit_text.delete();
		pick = $urandom_range(0, 99);
		if (!sgn && pick < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) lit_text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (!sgn && pick >= 40) begin
			if (pick < 60) begin
				base = 16;
				maxd = 16;
				pfx = $urandom_range(0, 1) ? CH_LC_X : CH_UC_X;
			end else if (pick < 80) begin
				base = 8;
				maxd = 22;
				pfx = $urandom_range(0, 1) ? CH_LC_O : CH_UC_O;
			end else begin
				base = 2;
				maxd = 64;
				pfx = $urandom_range(0, 1) ? CH_LC_B : CH_UC_B;
			end
			lit_text.push_back(CH_ZERO);
			lit_text.push_back(pfx);
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) lit_text.push_back(CH_ZERO);
			case ($urandom_range(0, 3))
				0, 1: n = $urandom_range(0, 8);
				2: n = $urandom_range(0, maxd + 1);
				default: n = $urandom_range(maxd - 1, maxd + 1);
			endcase
			repeat (n) lit_text.push_back(digit_char($urandom_range(0, base - 1)));
		end else begin
			if (sgn) repeat ($urandom_range(0, 3)) lit_text.push_back(CH_MINUS);
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) lit_text.push_back(CH_ZERO);
			top = sgn ? {1'b0, {63{1'b1}}} : {64{1'b1}};
			case ($urandom_range(0, 4))
				0, 1: begin
					num = 64'($urandom_range(0, 999999));
					s = $sformatf("%0d", num);
				end
				2: begin
					num = {$urandom, $urandom} & top;
					s = $sformatf("%0d", num);
				end
				3: begin
					num = top - 64'($urandom_range(0, 2));
					s = $sformatf("%0d", num);
				end
				default: begin
					num = top / 64'd10;
					s = $sformatf("%0d%0d", num,
						$urandom_range(int'(top % 64'd10) + 1, 9));
				end
			endcase
			for (int i = 0; i < s.len(); i++) lit_text.push_back(s[i]);
		end
		if ($urandom_range(0, 4) == 0) begin
			spot = $urandom_range(0, lit_text.size() - 1);
			case ($urandom_range(0, 7))
				0: lit_text[spot] = CH_NUL;
				1: lit_text[spot] = CH_MINUS;
				2: lit_text[spot] = CH_ZERO + 8'd8;
				3: lit_text[spot] = CH_ZERO + 8'd2;
				4: lit_text[spot] = CH_LC_F + 8'd1;
				5: lit_text[spot] = CH_UC_F + 8'd1;
				default: lit_text[spot] = 8'($urandom_range(0, 255));
			endcase
		end
		if ($urandom_range(0, 19) == 0) lit_text.push_back(CH_MINUS);
	endtask

	initial begin
		int unsigned stop_at;
		int unsigned phase_no;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unsigned corner cases
		set_mode(1'b0);
		send_text("0");
		send_text("0x");
		send_text("0o8");
		send_text("0b1");
		send_text("-1");
		send_text("0xF");
		lit_text = '{CH_NUL};
		send_literal();
		lit_text = '{8'hff};
		send_literal();
		go_idle();

		// signed corner cases
		set_mode(1'b1);
		send_text("--5");
		send_text("-");
		send_text("-7-");
		send_text("-0");

		phase_no = 0;
		while (items_sent < 1750) begin
			go_idle();
			set_mode(phase_no % 2 == 1);
			gaps_on = (phase_no % 3 != 2);
			stop_at = items_sent + 290;
			while (items_sent < stop_at && items_sent < 1750) begin
				make_literal(cur_mode);
				send_literal();
			end
			phase_no++;
		end
		go_idle();
		repeat (8) @(posedge clk);
		if (book.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
